// ===== rtl/core/i2cm_pkg.sv =====
// Shared types, codes and constants for the I2C master transaction sequencer.
`timescale 1ns / 1ps
`default_nettype none

package i2cm_pkg;

   // Default number of request slots in the ring
   localparam int QUEUE_DEPTH_DEF = 8;

   // Read/write bit in the address byte
   localparam logic [7:0] READ_BIT = 8'h01;

   // Request beat command codes
   typedef enum logic [1:0] {
      CMD_WRITE = 2'd0,
      CMD_READ  = 2'd1,
      CMD_EVENT = 2'd2,
      CMD_NOP   = 2'd3
   } cmd_type;

   // Bus actions requested from the controller
   typedef enum logic [2:0] {
      ACT_NONE  = 3'd0,
      ACT_START = 3'd1,
      ACT_TX    = 3'd2,
      ACT_RCEN  = 3'd3,
      ACT_ACK   = 3'd4,
      ACT_NACK  = 3'd5,
      ACT_STOP  = 3'd6
   } act_type;

   // Status reported with each response beat
   typedef enum logic [2:0] {
      STS_NONE      = 3'd0,
      STS_PENDING   = 3'd1,
      STS_COMPLETE  = 3'd2,
      STS_FAIL      = 3'd3,
      STS_ADDR_NACK = 3'd4,
      STS_DATA_NACK = 3'd5,
      STS_LOST      = 3'd6
   } sts_type;

   // Transaction sequencer states
   typedef enum logic [6:0] {
      SQ_IDLE      = 7'b0000001,
      SQ_SEND_ADDR = 7'b0000010,
      SQ_SEND_DATA = 7'b0000100,
      SQ_ACK_ADDR  = 7'b0001000,
      SQ_RCV_DATA  = 7'b0010000,
      SQ_ACK_RCV   = 7'b0100000,
      SQ_SEND_STOP = 7'b1000000
   } seq_type;

   // Class of a request beat after decode in the front end
   typedef enum logic [1:0] {
      KIND_ENQ    = 2'd0,
      KIND_EVENT  = 2'd1,
      KIND_IGNORE = 2'd2
   } kind_type;

   // Decoded request carried from the front end to the back end
   typedef struct packed {
      kind_type   kind;
      logic [7:0] addr_byte;
      logic [7:0] length;
      logic [7:0] tx_byte;
      logic       ack_missing;
      logic       write_collision;
      logic [7:0] rx_byte;
   } item_type;

endpackage

`default_nettype wire

// ===== rtl/core/i2cm_if.sv =====
// Valid/ready channel interfaces for request and response beats.
`timescale 1ns / 1ps
`default_nettype none

interface i2cm_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] cmd;
   logic [6:0] dev_address;
   logic [7:0] length;
   logic [7:0] tx_byte;
   logic       ack_missing;
   logic       write_collision;
   logic [7:0] rx_byte;

   modport source (
      output valid, cmd, dev_address, length, tx_byte, ack_missing, write_collision,
             rx_byte,
      input  ready
   );
   modport sink (
      input  valid, cmd, dev_address, length, tx_byte, ack_missing, write_collision,
             rx_byte,
      output ready
   );
endinterface

interface i2cm_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] bus_action;
   logic [7:0] tx_data;
   logic [7:0] rx_data;
   logic       rx_valid;
   logic [2:0] status;
   logic       kick;
   logic       queue_empty;
   logic       queue_full;
   logic [7:0] error_count;

   modport source (
      output valid, bus_action, tx_data, rx_data, rx_valid, status, kick, queue_empty,
             queue_full, error_count,
      input  ready
   );
   modport sink (
      input  valid, bus_action, tx_data, rx_data, rx_valid, status, kick, queue_empty,
             queue_full, error_count,
      output ready
   );
endinterface

`default_nettype wire

// ===== rtl/core/i2cm_front.sv =====
// Front end: decodes request beats into classified items for the command queue.
`timescale 1ns / 1ps
`default_nettype none

module i2cm_front (
   i2cm_req_if.sink            req_ch,
   output i2cm_pkg::item_type  push_item,
   output logic                push_valid,
   input  logic                push_ready
);

   i2cm_pkg::kind_type kind;
   logic [7:0]         rw_bit;

   // Classify the command and build the address byte
   always_comb begin
      rw_bit = 8'h00;
      unique case (i2cm_pkg::cmd_type'(req_ch.cmd)) inside
         i2cm_pkg::CMD_WRITE, i2cm_pkg::CMD_READ: begin
            kind = i2cm_pkg::KIND_ENQ;
            if (req_ch.cmd == i2cm_pkg::CMD_READ) begin
               rw_bit = i2cm_pkg::READ_BIT;
            end
         end
         i2cm_pkg::CMD_EVENT: begin
            kind = i2cm_pkg::KIND_EVENT;
         end
         default: begin
            kind = i2cm_pkg::KIND_IGNORE;
         end
      endcase
   end

   // Pack the item; stall the request side on a full queue
   always_comb begin
      push_item.kind            = kind;
      push_item.addr_byte       = {req_ch.dev_address, 1'b0} | rw_bit;
      push_item.length          = req_ch.length;
      push_item.tx_byte         = req_ch.tx_byte;
      push_item.ack_missing     = req_ch.ack_missing;
      push_item.write_collision = req_ch.write_collision;
      push_item.rx_byte         = req_ch.rx_byte;
   end

   assign push_valid   = req_ch.valid;
   assign req_ch.ready = push_ready;

endmodule

`default_nettype wire

// ===== rtl/core/i2cm_cmd_queue.sv =====
// Two-entry queue of decoded items between the front end and the back end.
`timescale 1ns / 1ps
`default_nettype none

module i2cm_cmd_queue (
   input  logic               clock,
   input  logic               reset,
   input  i2cm_pkg::item_type push_item,
   input  logic               push_valid,
   output logic               push_ready,
   output i2cm_pkg::item_type pop_item,
   output logic               pop_valid,
   input  logic               pop_ready
);

   i2cm_pkg::item_type slot_ff [2];
   logic               wr_ptr_ff;
   logic               rd_ptr_ff;
   logic [1:0]         count_ff;
   logic [1:0]         count_in;
   logic               push_fire;
   logic               pop_fire;

   assign push_ready = (count_ff != 2'd2);
   assign pop_valid  = (count_ff != 2'd0);
   assign pop_item   = slot_ff[rd_ptr_ff];
   assign push_fire  = push_valid && push_ready;
   assign pop_fire   = pop_valid && pop_ready;

   // Track occupancy
   always_comb begin
      count_in = count_ff;
      if (push_fire && !pop_fire) begin
         count_in = count_ff + 2'd1;
      end else if (pop_fire && !push_fire) begin
         count_in = count_ff - 2'd1;
      end
   end

   // Advance pointers and occupancy
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         count_ff <= count_in;
         if (push_fire) begin
            wr_ptr_ff <= ~wr_ptr_ff;
         end
         if (pop_fire) begin
            rd_ptr_ff <= ~rd_ptr_ff;
         end
      end
   end

   // Hold the payload
   always_ff @(posedge clock) begin
      if (push_fire) begin
         slot_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/i2cm_back.sv =====
// Back end: request ring, transaction sequencer, error count and response register.
`timescale 1ns / 1ps
`default_nettype none

module i2cm_back #(
   parameter int QUEUE_DEPTH = i2cm_pkg::QUEUE_DEPTH_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  i2cm_pkg::item_type pop_item,
   input  logic               pop_valid,
   output logic               pop_ready,
   i2cm_rsp_if.source         rsp_ch
);

   localparam int IDX_W = $clog2(QUEUE_DEPTH);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);

   // Ring storage: address byte over length
   logic [15:0]         ring_mem [QUEUE_DEPTH];
   logic [15:0]         rd_ff;

   i2cm_pkg::item_type  item_ff;
   logic                busy_ff;
   logic                fetch;
   logic                exec;

   i2cm_pkg::seq_type   seq_ff, seq_in;
   logic [IDX_W-1:0]    head_ff, head_in;
   logic [IDX_W-1:0]    tail_ff, tail_in;
   logic                empty_ff, empty_in;
   logic                full_ff, full_in;
   logic [7:0]          cab_ff, cab_in;
   logic [7:0]          rem_ff, rem_in;
   logic [7:0]          err_ff, err_in;
   logic [7:0]          rem_dec;
   logic [IDX_W-1:0]    head_nxt;
   logic [IDX_W-1:0]    tail_nxt;
   logic                wr_en;

   i2cm_pkg::act_type   act_ff, act_in;
   i2cm_pkg::sts_type   sts_ff, sts_in;
   logic [7:0]          txd_ff, txd_in;
   logic [7:0]          rxd_ff, rxd_in;
   logic                rxv_ff, rxv_in;
   logic                kick_ff, kick_in;
   logic                qe_ff, qf_ff;
   logic                rsp_valid_ff;

   function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] idx);
      logic [IDX_W-1:0] nxt;
      nxt = (idx == LAST_IDX) ? '0 : idx + IDX_W'(1);
      return nxt;
   endfunction

   // Fetch one item, then execute once the response slot is free
   assign pop_ready = !busy_ff;
   assign fetch     = pop_valid && !busy_ff;
   assign exec      = busy_ff && (!rsp_valid_ff || rsp_ch.ready);
   assign head_nxt  = next_slot(head_ff);
   assign tail_nxt  = next_slot(tail_ff);
   assign rem_dec   = rem_ff - 8'd1;

   // Step the ring and the sequencer for the fetched item
   always_comb begin
      seq_in   = seq_ff;
      head_in  = head_ff;
      tail_in  = tail_ff;
      empty_in = empty_ff;
      full_in  = full_ff;
      cab_in   = cab_ff;
      rem_in   = rem_ff;
      err_in   = err_ff;
      wr_en    = 1'b0;
      act_in   = i2cm_pkg::ACT_NONE;
      sts_in   = i2cm_pkg::STS_NONE;
      txd_in   = 8'h00;
      rxd_in   = 8'h00;
      rxv_in   = 1'b0;
      kick_in  = 1'b0;
      unique case (item_ff.kind)
         i2cm_pkg::KIND_ENQ: begin
            if (!full_ff) begin
               wr_en    = 1'b1;
               tail_in  = tail_nxt;
               empty_in = 1'b0;
               full_in  = (head_ff == tail_nxt);
               sts_in   = i2cm_pkg::STS_PENDING;
               kick_in  = (seq_ff == i2cm_pkg::SQ_IDLE);
            end else begin
               sts_in = i2cm_pkg::STS_FAIL;
            end
         end
         i2cm_pkg::KIND_EVENT: begin
            if (item_ff.write_collision) begin
               seq_in = i2cm_pkg::SQ_IDLE;
               sts_in = i2cm_pkg::STS_FAIL;
            end else begin
               unique case (seq_ff)
                  i2cm_pkg::SQ_IDLE: begin
                     if (!empty_ff) begin
                        cab_in   = rd_ff[15:8];
                        rem_in   = rd_ff[7:0];
                        head_in  = head_nxt;
                        full_in  = 1'b0;
                        empty_in = (head_nxt == tail_ff);
                        act_in   = i2cm_pkg::ACT_START;
                        seq_in   = i2cm_pkg::SQ_SEND_ADDR;
                     end
                  end
                  i2cm_pkg::SQ_SEND_ADDR: begin
                     act_in = i2cm_pkg::ACT_TX;
                     txd_in = cab_ff;
                     seq_in = ((cab_ff & i2cm_pkg::READ_BIT) != 8'h00)
                              ? i2cm_pkg::SQ_ACK_ADDR : i2cm_pkg::SQ_SEND_DATA;
                  end
                  i2cm_pkg::SQ_SEND_DATA: begin
                     if (item_ff.ack_missing) begin
                        err_in = err_ff + 8'd1;
                        act_in = i2cm_pkg::ACT_STOP;
                        sts_in = i2cm_pkg::STS_DATA_NACK;
                        seq_in = i2cm_pkg::SQ_IDLE;
                     end else if (rem_ff == 8'd0) begin
                        act_in = i2cm_pkg::ACT_STOP;
                        sts_in = i2cm_pkg::STS_COMPLETE;
                        seq_in = i2cm_pkg::SQ_IDLE;
                     end else begin
                        rem_in = rem_dec;
                        act_in = i2cm_pkg::ACT_TX;
                        txd_in = item_ff.tx_byte;
                     end
                  end
                  i2cm_pkg::SQ_ACK_ADDR: begin
                     if (item_ff.ack_missing) begin
                        err_in = err_ff + 8'd1;
                        act_in = i2cm_pkg::ACT_STOP;
                        sts_in = i2cm_pkg::STS_ADDR_NACK;
                        seq_in = i2cm_pkg::SQ_IDLE;
                     end else begin
                        act_in = i2cm_pkg::ACT_RCEN;
                        seq_in = i2cm_pkg::SQ_ACK_RCV;
                     end
                  end
                  i2cm_pkg::SQ_RCV_DATA: begin
                     act_in = i2cm_pkg::ACT_RCEN;
                     seq_in = i2cm_pkg::SQ_ACK_RCV;
                  end
                  i2cm_pkg::SQ_ACK_RCV: begin
                     rxd_in = item_ff.rx_byte;
                     rxv_in = 1'b1;
                     rem_in = rem_dec;
                     if (rem_dec != 8'd0) begin
                        act_in = i2cm_pkg::ACT_ACK;
                        seq_in = i2cm_pkg::SQ_RCV_DATA;
                     end else begin
                        act_in = i2cm_pkg::ACT_NACK;
                        seq_in = i2cm_pkg::SQ_SEND_STOP;
                     end
                  end
                  i2cm_pkg::SQ_SEND_STOP: begin
                     act_in = i2cm_pkg::ACT_STOP;
                     sts_in = i2cm_pkg::STS_COMPLETE;
                     seq_in = i2cm_pkg::SQ_IDLE;
                  end
                  default: begin
                     // Corrupted state: count it and drop the transfer
                     err_in = err_ff + 8'd1;
                     act_in = i2cm_pkg::ACT_STOP;
                     sts_in = i2cm_pkg::STS_LOST;
                     seq_in = i2cm_pkg::SQ_IDLE;
                  end
               endcase
            end
         end
         default: begin
         end
      endcase
   end

   // Control state and response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         seq_ff       <= i2cm_pkg::SQ_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         empty_ff     <= 1'b1;
         full_ff      <= 1'b0;
         cab_ff       <= 8'h00;
         rem_ff       <= 8'h00;
         err_ff       <= 8'h00;
      end else begin
         if (fetch) begin
            busy_ff <= 1'b1;
         end
         if (exec) begin
            busy_ff      <= 1'b0;
            rsp_valid_ff <= 1'b1;
            seq_ff       <= seq_in;
            head_ff      <= head_in;
            tail_ff      <= tail_in;
            empty_ff     <= empty_in;
            full_ff      <= full_in;
            cab_ff       <= cab_in;
            rem_ff       <= rem_in;
            err_ff       <= err_in;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Ring memory: write at tail on execute, registered read of head on fetch
   always_ff @(posedge clock) begin
      if (exec && wr_en) begin
         ring_mem[tail_ff] <= {item_ff.addr_byte, item_ff.length};
      end
      if (fetch) begin
         rd_ff <= ring_mem[head_ff];
      end
   end

   // Item and response payload
   always_ff @(posedge clock) begin
      if (fetch) begin
         item_ff <= pop_item;
      end
      if (exec) begin
         act_ff  <= act_in;
         sts_ff  <= sts_in;
         txd_ff  <= txd_in;
         rxd_ff  <= rxd_in;
         rxv_ff  <= rxv_in;
         kick_ff <= kick_in;
         qe_ff   <= empty_in;
         qf_ff   <= full_in;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.bus_action  = act_ff;
   assign rsp_ch.tx_data     = txd_ff;
   assign rsp_ch.rx_data     = rxd_ff;
   assign rsp_ch.rx_valid    = rxv_ff;
   assign rsp_ch.status      = sts_ff;
   assign rsp_ch.kick        = kick_ff;
   assign rsp_ch.queue_empty = qe_ff;
   assign rsp_ch.queue_full  = qf_ff;
   assign rsp_ch.error_count = err_ff;

endmodule

`default_nettype wire

// ===== rtl/core/i2c_master_transaction_sequencer_unit.sv =====
// Top level of the I2C master transaction sequencer.
`timescale 1ns / 1ps
`default_nettype none

// Every request beat (enqueue write, enqueue read, bus controller event or an
// ignored code) yields exactly one response beat, in order. A beat is decoded
// in the front end and parked in a two-entry command queue, so the request side
// keeps flowing, until the queue fills, while a response waits to be taken.
// The back end takes one item at a time, fetching the next only after the
// last is executed: first the registered read of the head slot of the
// request ring memory, then, once the response register is free, the
// sequencer step and the load of the response register. Requests hold a
// 7-bit address and a byte length; QUEUE_DEPTH sets the number of ring
// slots. No clearing pass is needed after reset.
module i2c_master_transaction_sequencer_unit #(
   parameter int QUEUE_DEPTH = i2cm_pkg::QUEUE_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   i2cm_req_if.sink   req_ch,
   i2cm_rsp_if.source rsp_ch
);

   i2cm_pkg::item_type push_item;
   logic               push_valid;
   logic               push_ready;
   i2cm_pkg::item_type pop_item;
   logic               pop_valid;
   logic               pop_ready;

   i2cm_front u_front (
      .req_ch     (req_ch),
      .push_item  (push_item),
      .push_valid (push_valid),
      .push_ready (push_ready)
   );

   i2cm_cmd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_item  (push_item),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .pop_item   (pop_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready)
   );

   i2cm_back #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_item  (pop_item),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .rsp_ch    (rsp_ch)
   );

endmodule

`default_nettype wire

// ===== rtl/core/i2cm_checker.sv =====
// Port-level checks for the I2C master transaction sequencer, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module i2cm_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [2:0] rsp_bus_action,
   input logic [2:0] rsp_status,
   input logic       rsp_rx_valid,
   input logic       rsp_kick,
   input logic       rsp_queue_empty,
   input logic       rsp_queue_full,
   input logic [7:0] rsp_error_count
);

   // Nack and lost-state reports always close the transfer with a stop
   a_err_stops: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == i2cm_pkg::STS_ADDR_NACK ||
                    rsp_status == i2cm_pkg::STS_DATA_NACK ||
                    rsp_status == i2cm_pkg::STS_LOST)
      |-> rsp_bus_action == i2cm_pkg::ACT_STOP)
      else $error("error status without stop");

   // A received byte comes only with its ack or nack
   a_rx_ack: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_rx_valid
      |-> (rsp_bus_action == i2cm_pkg::ACT_ACK || rsp_bus_action == i2cm_pkg::ACT_NACK))
      else $error("rx byte without ack or nack");

   // Kick only on a successful enqueue
   a_kick_pending: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kick |-> rsp_status == i2cm_pkg::STS_PENDING)
      else $error("kick without pending status");

   // Ring cannot be empty and full together
   a_flags_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_queue_empty && rsp_queue_full))
      else $error("queue both empty and full");

   // Stalled response holds its count and status
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready
      |=> rsp_valid && $stable(rsp_error_count) && $stable(rsp_status))
      else $error("stalled response changed");

endmodule

bind i2c_master_transaction_sequencer_unit i2cm_checker u_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_bus_action  (rsp_ch.bus_action),
   .rsp_status      (rsp_ch.status),
   .rsp_rx_valid    (rsp_ch.rx_valid),
   .rsp_kick        (rsp_ch.kick),
   .rsp_queue_empty (rsp_ch.queue_empty),
   .rsp_queue_full  (rsp_ch.queue_full),
   .rsp_error_count (rsp_ch.error_count)
);

`default_nettype wire

// ===== tb/i2c_master_transaction_sequencer_unit_test.sv =====
// Self-checking testbench for the I2C master transaction sequencer unit.
`timescale 1ns / 1ps

module i2c_master_transaction_sequencer_unit_test;

   localparam int QDEPTH       = i2cm_pkg::QUEUE_DEPTH_DEF;
   localparam int STALL_LIMIT  = 3000;
   localparam int HOLD_OFF     = 120;
   localparam int TAIL_CYCLES  = 8;
   localparam int IDLE_PCT     = 24;
   localparam int MAX_PRINTS   = 30;
   localparam int RANDOM_BEATS = 170;

   typedef struct {
      i2cm_pkg::cmd_type cmd;
      logic [6:0]        dev_address;
      logic [7:0]        length;
      logic [7:0]        tx_byte;
      logic              ack_missing;
      logic              write_collision;
      logic [7:0]        rx_byte;
   } req_beat_type;

   typedef struct {
      i2cm_pkg::act_type bus_action;
      logic [7:0]        tx_data;
      logic [7:0]        rx_data;
      logic              rx_valid;
      i2cm_pkg::sts_type status;
      logic              kick;
      logic              queue_empty;
      logic              queue_full;
      logic [7:0]        error_count;
   } bus_step_type;

   logic clock = 1'b0;
   logic reset;

   i2cm_req_if req_bus();
   i2cm_rsp_if rsp_bus();

   i2c_master_transaction_sequencer_unit dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   // Shadow copy of the sequencer and its request ring
   i2cm_pkg::seq_type sq_state;
   logic [15:0] ring [QDEPTH];
   int unsigned head_slot;
   int unsigned tail_slot;
   logic        q_empty;
   logic        q_full;
   logic [7:0]  cur_addr_byte;
   logic [7:0]  bytes_left;
   logic [7:0]  err_tally;

   bus_step_type steps_due [$];
   int  mismatches      = 0;
   int  beats_sent      = 0;
   int  beats_checked   = 0;
   int  hold_off_cycles = 0;
   int  quiet_cycles    = 0;
   bit  steady          = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic bit pct(input int p);
      return $urandom_range(0, 99) < p;
   endfunction

   task automatic report_mismatch(input string msg);
      mismatches++;
      if (mismatches <= MAX_PRINTS) $display("MISMATCH at %0t: %s", $time, msg);
   endtask

   task automatic check_field(input string name, input logic [7:0] got, input logic [7:0] want);
      if (got !== want)
         report_mismatch($sformatf("beat %0d %s got %0h want %0h", beats_checked, name, got, want));
   endtask

   // Count a nack or lost-state error in the 8-bit wrapping tally
   function automatic void bump_errors();
      err_tally = err_tally + 8'd1;
   endfunction

   // Close the transfer with a stop and return to idle
   function automatic void end_transfer(inout bus_step_type r, input i2cm_pkg::sts_type code);
      r.bus_action = i2cm_pkg::ACT_STOP;
      r.status     = code;
      sq_state     = i2cm_pkg::SQ_IDLE;
   endfunction

   // Advance the shadow sequencer by one request beat and return its response
   function automatic bus_step_type predict_bus_step(input req_beat_type b);
      bus_step_type r;
      logic [15:0]  slot;
      logic [7:0]   addr_byte;
      r.bus_action = i2cm_pkg::ACT_NONE;
      r.tx_data    = 8'h00;
      r.rx_data    = 8'h00;
      r.rx_valid   = 1'b0;
      r.status     = i2cm_pkg::STS_NONE;
      r.kick       = 1'b0;
      case (b.cmd)
         i2cm_pkg::CMD_WRITE, i2cm_pkg::CMD_READ: begin
            if (!q_full) begin
               addr_byte = {b.dev_address, 1'b0} |
                           ((b.cmd == i2cm_pkg::CMD_READ) ? i2cm_pkg::READ_BIT : 8'h00);
               ring[tail_slot] = {addr_byte, b.length};
               tail_slot = (tail_slot + 1 == QDEPTH) ? 0 : tail_slot + 1;
               q_empty = 1'b0;
               if (head_slot == tail_slot) q_full = 1'b1;
               r.status = i2cm_pkg::STS_PENDING;
               r.kick   = (sq_state == i2cm_pkg::SQ_IDLE);
            end else begin
               r.status = i2cm_pkg::STS_FAIL;
            end
         end
         i2cm_pkg::CMD_EVENT: begin
            if (b.write_collision) begin
               // Collision drops any transfer, even when idle
               sq_state = i2cm_pkg::SQ_IDLE;
               r.status = i2cm_pkg::STS_FAIL;
            end else begin
               case (sq_state)
                  i2cm_pkg::SQ_IDLE: begin
                     if (!q_empty) begin
                        slot          = ring[head_slot];
                        cur_addr_byte = slot[15:8];
                        bytes_left    = slot[7:0];
                        head_slot     = (head_slot + 1 == QDEPTH) ? 0 : head_slot + 1;
                        q_full        = 1'b0;
                        if (head_slot == tail_slot) q_empty = 1'b1;
                        r.bus_action  = i2cm_pkg::ACT_START;
                        sq_state      = i2cm_pkg::SQ_SEND_ADDR;
                     end
                  end
                  i2cm_pkg::SQ_SEND_ADDR: begin
                     r.bus_action = i2cm_pkg::ACT_TX;
                     r.tx_data    = cur_addr_byte;
                     sq_state = ((cur_addr_byte & i2cm_pkg::READ_BIT) != 8'h00)
                                ? i2cm_pkg::SQ_ACK_ADDR : i2cm_pkg::SQ_SEND_DATA;
                  end
                  i2cm_pkg::SQ_SEND_DATA: begin
                     // A nack of the write address shows up here as a data nack
                     if (b.ack_missing) begin
                        bump_errors();
                        end_transfer(r, i2cm_pkg::STS_DATA_NACK);
                     end else if (bytes_left == 8'd0) begin
                        end_transfer(r, i2cm_pkg::STS_COMPLETE);
                     end else begin
                        bytes_left   = bytes_left - 8'd1;
                        r.bus_action = i2cm_pkg::ACT_TX;
                        r.tx_data    = b.tx_byte;
                     end
                  end
                  i2cm_pkg::SQ_ACK_ADDR: begin
                     if (b.ack_missing) begin
                        bump_errors();
                        end_transfer(r, i2cm_pkg::STS_ADDR_NACK);
                     end else begin
                        r.bus_action = i2cm_pkg::ACT_RCEN;
                        sq_state     = i2cm_pkg::SQ_ACK_RCV;
                     end
                  end
                  i2cm_pkg::SQ_RCV_DATA: begin
                     r.bus_action = i2cm_pkg::ACT_RCEN;
                     sq_state     = i2cm_pkg::SQ_ACK_RCV;
                  end
                  i2cm_pkg::SQ_ACK_RCV: begin
                     // Length zero wraps here, giving 256 bytes
                     r.rx_data  = b.rx_byte;
                     r.rx_valid = 1'b1;
                     bytes_left = bytes_left - 8'd1;
                     if (bytes_left != 8'd0) begin
                        r.bus_action = i2cm_pkg::ACT_ACK;
                        sq_state     = i2cm_pkg::SQ_RCV_DATA;
                     end else begin
                        r.bus_action = i2cm_pkg::ACT_NACK;
                        sq_state     = i2cm_pkg::SQ_SEND_STOP;
                     end
                  end
                  i2cm_pkg::SQ_SEND_STOP: end_transfer(r, i2cm_pkg::STS_COMPLETE);
                  default: begin
                     bump_errors();
                     end_transfer(r, i2cm_pkg::STS_LOST);
                  end
               endcase
            end
         end
         default: ;
      endcase
      r.queue_empty = q_empty;
      r.queue_full  = q_full;
      r.error_count = err_tally;
      return r;
   endfunction

   function automatic req_beat_type beat_of(input i2cm_pkg::cmd_type c, input logic [6:0] a,
                                            input logic [7:0] len, input logic [7:0] tx,
                                            input logic nack, input logic wcol,
                                            input logic [7:0] rx);
      req_beat_type b;
      b.cmd             = c;
      b.dev_address     = a;
      b.length          = len;
      b.tx_byte         = tx;
      b.ack_missing     = nack;
      b.write_collision = wcol;
      b.rx_byte         = rx;
      return b;
   endfunction

   // Random content; mostly short transfers, now and then a long one
   function automatic req_beat_type random_beat(input i2cm_pkg::cmd_type c);
      req_beat_type b;
      b.cmd             = c;
      b.dev_address     = 7'($urandom_range(0, 127));
      b.tx_byte         = 8'($urandom_range(0, 255));
      b.rx_byte         = 8'($urandom_range(0, 255));
      b.ack_missing     = pct(6);
      b.write_collision = pct(2);
      if (c == i2cm_pkg::CMD_READ)
         b.length = pct(3) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(1, 5));
      else if (c == i2cm_pkg::CMD_WRITE)
         b.length = pct(5) ? 8'($urandom_range(0, 255)) : 8'($urandom_range(0, 5));
      else
         b.length = 8'($urandom_range(0, 255));
      return b;
   endfunction

   function automatic i2cm_pkg::cmd_type random_enqueue();
      return pct(50) ? i2cm_pkg::CMD_READ : i2cm_pkg::CMD_WRITE;
   endfunction

   // Offer one beat, with optional idle cycles first, and hold it until accepted
   task automatic send_beat(input req_beat_type b);
      while (!steady && pct(IDLE_PCT)) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid           <= 1'b1;
      req_bus.cmd             <= b.cmd;
      req_bus.dev_address     <= b.dev_address;
      req_bus.length          <= b.length;
      req_bus.tx_byte         <= b.tx_byte;
      req_bus.ack_missing     <= b.ack_missing;
      req_bus.write_collision <= b.write_collision;
      req_bus.rx_byte         <= b.rx_byte;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      steps_due.push_back(predict_bus_step(b));
      beats_sent++;
   endtask

   // Drop valid and wait for every outstanding response
   task automatic drain_responses();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (steps_due.size() != 0);
   endtask

   // Step clean bus events until the sequencer is idle with an empty ring
   task automatic finish_queue();
      req_beat_type b;
      while (sq_state != i2cm_pkg::SQ_IDLE || !q_empty) begin
         b = random_beat(i2cm_pkg::CMD_EVENT);
         b.ack_missing     = 1'b0;
         b.write_collision = 1'b0;
         send_beat(b);
      end
   endtask

   task automatic check_response();
      bus_step_type want;
      if (steps_due.size() == 0) begin
         report_mismatch("response beat with nothing expected");
         return;
      end
      want = steps_due.pop_front();
      check_field("bus_action", 8'(rsp_bus.bus_action), 8'(want.bus_action));
      check_field("tx_data", rsp_bus.tx_data, want.tx_data);
      check_field("rx_data", rsp_bus.rx_data, want.rx_data);
      check_field("rx_valid", 8'(rsp_bus.rx_valid), 8'(want.rx_valid));
      check_field("status", 8'(rsp_bus.status), 8'(want.status));
      check_field("kick", 8'(rsp_bus.kick), 8'(want.kick));
      check_field("queue_empty", 8'(rsp_bus.queue_empty), 8'(want.queue_empty));
      check_field("queue_full", 8'(rsp_bus.queue_full), 8'(want.queue_full));
      check_field("error_count", rsp_bus.error_count, want.error_count);
      beats_checked++;
   endtask

   // Events on an idle bus, an ignored code and a collision with nothing active
   task automatic check_idle_events();
      send_beat(beat_of(i2cm_pkg::CMD_EVENT, 7'h2A, 8'h10, 8'hA5, 1'b0, 1'b0, 8'h5A));
      send_beat(beat_of(i2cm_pkg::CMD_NOP, 7'h7F, 8'hFF, 8'hFF, 1'b1, 1'b1, 8'hFF));
      send_beat(beat_of(i2cm_pkg::CMD_EVENT, 7'h00, 8'h00, 8'h00, 1'b0, 1'b1, 8'h00));
      drain_responses();
   endtask

   // One-byte write to the top address, ending with a stop
   task automatic check_write_transfer();
      send_beat(beat_of(i2cm_pkg::CMD_WRITE, 7'h7F, 8'd1, 8'h00, 1'b0, 1'b0, 8'h00));
      send_beat(beat_of(i2cm_pkg::CMD_EVENT, 7'h00, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00));
      send_beat(beat_of(i2cm_pkg::CMD_EVENT, 7'h00, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00));
      send_beat(beat_of(i2cm_pkg::CMD_EVENT, 7'h00, 8'h00, 8'hFF, 1'b0, 1'b0, 8'h00));
      send_beat(beat_of(i2cm_pkg::CMD_EVENT, 7'h00, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00));
      drain_responses();
   endtask

   // One-byte read from address zero; a nack on the address send is ignored
   task automatic check_read_transfer();
      send_beat(beat_of(i2cm_pkg::CMD_READ, 7'h00, 8'd1, 8'h00, 1'b0, 1'b0, 8'h00));
      send_beat(beat_of(i2cm_pkg::CMD_EVENT, 7'h00, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00));
      send_beat(beat_of(i2cm_pkg::CMD_EVENT, 7'h00, 8'h00, 8'h00, 1'b1, 1'b0, 8'h00));
      send_beat(beat_of(i2cm_pkg::CMD_EVENT, 7'h00, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00));
      send_beat(beat_of(i2cm_pkg::CMD_EVENT, 7'h00, 8'h00, 8'h00, 1'b0, 1'b0, 8'hFF));
      send_beat(beat_of(i2cm_pkg::CMD_EVENT, 7'h00, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00));
      drain_responses();
   endtask

   // Data nack on a write, address nack on a read
   task automatic check_nack_paths();
      send_beat(beat_of(i2cm_pkg::CMD_WRITE, 7'h55, 8'd3, 8'h00, 1'b0, 1'b0, 8'h00));
      send_beat(beat_of(i2cm_pkg::CMD_EVENT, 7'h00, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00));
      send_beat(beat_of(i2cm_pkg::CMD_EVENT, 7'h00, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00));
      send_beat(beat_of(i2cm_pkg::CMD_EVENT, 7'h00, 8'h00, 8'h3C, 1'b1, 1'b0, 8'h00));
      send_beat(beat_of(i2cm_pkg::CMD_READ, 7'h2A, 8'd4, 8'h00, 1'b0, 1'b0, 8'h00));
      send_beat(beat_of(i2cm_pkg::CMD_EVENT, 7'h00, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00));
      send_beat(beat_of(i2cm_pkg::CMD_EVENT, 7'h00, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00));
      send_beat(beat_of(i2cm_pkg::CMD_EVENT, 7'h00, 8'h00, 8'h00, 1'b1, 1'b0, 8'h00));
      drain_responses();
   endtask

   // Collision in the middle of a transfer
   task automatic check_collision();
      send_beat(beat_of(i2cm_pkg::CMD_WRITE, 7'h01, 8'd2, 8'h00, 1'b0, 1'b0, 8'h00));
      send_beat(beat_of(i2cm_pkg::CMD_EVENT, 7'h00, 8'h00, 8'h00, 1'b0, 1'b0, 8'h00));
      send_beat(beat_of(i2cm_pkg::CMD_EVENT, 7'h00, 8'h00, 8'h00, 1'b0, 1'b1, 8'h00));
      drain_responses();
   endtask

   // Fill the ring, then one enqueue more that must fail
   task automatic check_queue_full();
      for (int i = 0; i <= QDEPTH; i++) send_beat(random_beat(random_enqueue()));
      drain_responses();
   endtask

   // Hold the response side off while requests keep coming
   task automatic check_backpressure();
      hold_off_cycles = HOLD_OFF;
      for (int i = 0; i < 20; i++)
         send_beat(random_beat(pct(30) ? random_enqueue() : i2cm_pkg::CMD_EVENT));
      drain_responses();
   endtask

   // Mostly complete transfers with random content, plus noise
   task automatic check_random_traffic(input int count);
      int roll;
      for (int i = 0; i < count; i++) begin
         steady = (i >= count / 3 && i < count / 2);
         roll = $urandom_range(0, 99);
         if (roll < 4)
            send_beat(random_beat(i2cm_pkg::CMD_NOP));
         else if (roll < 16 || (sq_state == i2cm_pkg::SQ_IDLE && q_empty && roll < 70))
            send_beat(random_beat(random_enqueue()));
         else
            send_beat(random_beat(i2cm_pkg::CMD_EVENT));
      end
      steady = 1'b0;
      drain_responses();
   endtask

   // A read of length zero moves 256 bytes
   task automatic check_longest_read();
      finish_queue();
      send_beat(beat_of(i2cm_pkg::CMD_READ, 7'($urandom_range(0, 127)), 8'd0, 8'h00,
                        1'b0, 1'b0, 8'h00));
      finish_queue();
      drain_responses();
   endtask

   // Response side: check accepted beats, then pick ready for the next edge
   initial begin
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_bus.valid && rsp_bus.ready) check_response();
         if (hold_off_cycles > 0) begin
            rsp_bus.ready <= 1'b0;
            hold_off_cycles--;
         end else begin
            rsp_bus.ready <= steady || !pct(IDLE_PCT);
         end
      end
   end

   // Watchdog: give up when neither channel moves a beat for too long
   initial begin
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("Watchdog: no beat moved for %0d cycles", STALL_LIMIT);
      $display("CHECKS FAILED");
      $finish;
   end

   initial begin
      reset                   <= 1'b1;
      req_bus.valid           <= 1'b0;
      req_bus.cmd             <= i2cm_pkg::CMD_NOP;
      req_bus.dev_address     <= 7'h00;
      req_bus.length          <= 8'h00;
      req_bus.tx_byte         <= 8'h00;
      req_bus.ack_missing     <= 1'b0;
      req_bus.write_collision <= 1'b0;
      req_bus.rx_byte         <= 8'h00;
      sq_state      = i2cm_pkg::SQ_IDLE;
      head_slot     = 0;
      tail_slot     = 0;
      q_empty       = 1'b1;
      q_full        = 1'b0;
      cur_addr_byte = 8'h00;
      bytes_left    = 8'h00;
      err_tally     = 8'h00;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      check_idle_events();
      check_write_transfer();
      check_read_transfer();
      check_nack_paths();
      check_collision();
      check_queue_full();
      check_backpressure();
      check_random_traffic(RANDOM_BEATS);
      check_longest_read();

      // Let any stray response surface before closing
      drain_responses();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (steps_due.size() != 0)
         report_mismatch($sformatf("%0d responses never arrived", steps_due.size()));

      $display("Run: %0d request beats, %0d response beats checked, %0d mismatches",
               beats_sent, beats_checked, mismatches);
      $display("Covered writes, reads up to 256 bytes, nacks, collisions, a full ring");
      $display("and long response back-pressure with the request side stalled");
      if (mismatches == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
